### hdl/dq_pkg.sv
// Shared types, codes and default sizes for the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_LIST_ALL   = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_R,
        OP_SHIFT_L,
        OP_WRITE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } dq_state_t;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [VALUE_W-1:0] push_value;
    } dq_req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last_of_run;
    } dq_rsp_t;

endpackage

### hdl/dq_cell.sv
// One storage cell of the queue chain; cell zero always holds the front entry.
module dq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  dq_pkg::cell_op_t      op,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] front_data,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  is_slot;
    logic                  is_last;

    assign is_slot = (count == CNT_W'(INDEX));
    assign is_last = (count == CNT_W'(INDEX + 1));

    always_comb
    begin
        data_next = data_reg;
        case (op)
            OP_SHIFT_R: data_next = left_data;
            OP_SHIFT_L: data_next = right_data;
            OP_WRITE:
            begin
                if (is_slot)
                begin
                    data_next = push_data;
                end
            end
            OP_ROTATE:
            begin
                // Entries below the back move one step forward; the old front wraps to the back.
                if (is_last)
                begin
                    data_next = front_data;
                end
                else if (count > CNT_W'(INDEX + 1))
                begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = is_last ? data_reg : '0;

endmodule

### hdl/double_ended_queue.sv
// Top level of the double-ended queue built as a chain of storage cells.
// Push and pop transactions register their result on accept; it is valid in the next cycle.
// A list transaction is accepted, then emits each stored entry from the front by the rotation
// of the cell chain that brings each entry to the front cell in turn; a result stall holds it.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the result valid flag;
// the cell contents are not reset and are only read after being written.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dq_pkg::dq_req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dq_pkg::dq_rsp_t rsp
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // The queue state is the entry count; the cells keep entries in order from the front.
    dq_state_t        state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] list_cnt_reg, list_cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    dq_rsp_t          rsp_reg, rsp_next;

    cell_op_t              op;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
    logic [DATA_WIDTH-1:0] back_data;
    logic                  slot_free;
    logic                  req_accept;
    logic                  list_last;

    // Data stored is the low DATA_WIDTH bits of the pushed word.
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH+VALUE_W-1:0] wide;
        wide = {{DATA_WIDTH{1'b0}}, v};
        return wide[DATA_WIDTH-1:0];
    endfunction

    // Results carry the stored word sign-extended and cut to the output width.
    function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] s);
        logic [DATA_WIDTH+VALUE_W-1:0] wide;
        wide = {{VALUE_W{s[DATA_WIDTH-1]}}, s};
        return wide[VALUE_W-1:0];
    endfunction

    assign push_data = to_store(req.push_value);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_in;
            logic [DATA_WIDTH-1:0] right_in;
            if (gi == 0)
            begin : g_first
                assign left_in = push_data;
            end
            else
            begin : g_mid
                assign left_in = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign right_in = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_in = cell_data[gi+1];
            end
            dq_cell #(
                .DATA_WIDTH(DATA_WIDTH),
                .CNT_W     (CNT_W),
                .INDEX     (gi)
            ) u_cell (
                .clk       (clk),
                .op        (op),
                .count     (count_reg),
                .left_data (left_in),
                .right_data(right_in),
                .front_data(cell_data[0]),
                .push_data (push_data),
                .data      (cell_data[gi]),
                .tap       (cell_tap[gi])
            );
        end
    endgenerate

    // Only the cell holding the back entry drives its tap, so an OR gathers the back word.
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | cell_tap[i];
        end
    end

    // The output register can take a new result when empty or being drained this cycle.
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg == ST_LIST) || !slot_free;
    assign req_accept = req_valid && !req_stall;
    assign list_last  = (list_cnt_reg + CNT_W'(1) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        list_cnt_next  = list_cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op             = OP_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    unique case (req.req_type) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                rsp_next = '{status: STS_FULL, out_value: '0, last_of_run: 1'b1};
                            end
                            else
                            begin
                                op = (req.req_type == REQ_PUSH_FRONT) ? OP_SHIFT_R : OP_WRITE;
                                count_next = count_reg + CNT_W'(1);
                                rsp_next = '{status: STS_OK, out_value: to_out(push_data),
                                             last_of_run: 1'b1};
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                rsp_next = '{status: STS_EMPTY, out_value: '0, last_of_run: 1'b1};
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (req.req_type == REQ_POP_FRONT)
                                begin
                                    op = OP_SHIFT_L;
                                    rsp_next = '{status: STS_OK, out_value: to_out(cell_data[0]),
                                                 last_of_run: 1'b1};
                                end
                                else
                                begin
                                    rsp_next = '{status: STS_OK, out_value: to_out(back_data),
                                                 last_of_run: 1'b1};
                                end
                            end
                        end
                        REQ_LIST_ALL:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = '{status: STS_EMPTY, out_value: '0, last_of_run: 1'b1};
                            end
                            else
                            begin
                                state_next    = ST_LIST;
                                list_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                            // Unknown request codes are consumed with no result.
                            op = OP_HOLD;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (slot_free)
                begin
                    // Emit the front entry and rotate it to the back; after a full
                    // pass the chain is back in its original order.
                    rsp_valid_next = 1'b1;
                    rsp_next = '{status: STS_OK, out_value: to_out(cell_data[0]),
                                 last_of_run: list_last};
                    op            = OP_ROTATE;
                    list_cnt_next = list_cnt_reg + CNT_W'(1);
                    if (list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            list_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_cnt_reg  <= list_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (count_reg != '0) && (list_cnt_reg < count_reg))
        else $error("list pass running past the stored entries");

    a_list_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == ST_LIST) |-> rsp_valid_reg && rsp_reg.last_of_run)
        else $error("list pass ended without a marked final result");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed during a list pass");

    a_count_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !req_accept && (state_reg == ST_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed without a transaction");
`endif

endmodule

### verif/dq_checker.sv
`timescale 1ns / 1ps
// Checker for the double-ended queue: predicts results from accepted requests and compares them.
module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  dq_pkg::dq_req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  dq_pkg::dq_rsp_t rsp,
    output int              fail_count,
    output int              pending,
    output int              checked,
    output int              full_refusals,
    output int              empty_reports,
    output int              longest_list
);
    import dq_pkg::*;

    // Shadow copy of the ring: slots, front slot and number of stored entries.
    logic signed [VALUE_W-1:0] entry_copy [DEPTH];
    int                        head_slot;
    int                        held_count;

    dq_rsp_t expected_rsp_q [$];
    dq_rsp_t want;

    function automatic dq_rsp_t make_rsp(input status_code_t st,
                                         input logic signed [VALUE_W-1:0] value,
                                         input logic last);
        dq_rsp_t r;
        r.status      = st;
        r.out_value   = value;
        r.last_of_run = last;
        return r;
    endfunction

    // Applies one accepted request to the shadow ring and queues the results it causes.
    task automatic predict_queue_op(input dq_req_t item);
        int slot;
        case (item.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (held_count >= DEPTH)
                begin
                    expected_rsp_q.push_back(make_rsp(STS_FULL, '0, 1'b1));
                    full_refusals++;
                end
                else
                begin
                    if (item.req_type == REQ_PUSH_FRONT)
                    begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        slot = head_slot;
                    end
                    else
                    begin
                        slot = (head_slot + held_count) % DEPTH;
                    end
                    entry_copy[slot] = item.push_value;
                    held_count++;
                    expected_rsp_q.push_back(make_rsp(STS_OK, item.push_value, 1'b1));
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (held_count == 0)
                begin
                    expected_rsp_q.push_back(make_rsp(STS_EMPTY, '0, 1'b1));
                    empty_reports++;
                end
                else
                begin
                    if (item.req_type == REQ_POP_FRONT)
                    begin
                        slot = head_slot;
                        head_slot = (head_slot + 1) % DEPTH;
                    end
                    else
                    begin
                        slot = (head_slot + held_count - 1) % DEPTH;
                    end
                    // Removing from the back leaves the front slot where it is; a front removal always advances it.
                    held_count--;
                    expected_rsp_q.push_back(make_rsp(STS_OK, entry_copy[slot], 1'b1));
                end
            end
            REQ_LIST_ALL:
            begin
                if (held_count == 0)
                begin
                    expected_rsp_q.push_back(make_rsp(STS_EMPTY, '0, 1'b1));
                    empty_reports++;
                end
                else
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        expected_rsp_q.push_back(make_rsp(STS_OK,
                            entry_copy[(head_slot + i) % DEPTH], i == held_count - 1));
                    end
                    if (held_count > longest_list)
                    begin
                        longest_list = held_count;
                    end
                end
            end
            default:
            begin
                // Unused request codes are dropped without a result.
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot     = 0;
            held_count    = 0;
            fail_count    = 0;
            checked       = 0;
            full_refusals = 0;
            empty_reports = 0;
            longest_list  = 0;
            expected_rsp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_queue_op(req);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d value=%0d last=%0b",
                             $time, rsp.status, rsp.out_value, rsp.last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    checked++;
                    if (rsp.status !== want.status || rsp.out_value !== want.out_value ||
                        rsp.last_of_run !== want.last_of_run)
                    begin
                        $display({"%0t: result mismatch: expected status=%0d value=%0d ",
                                  "last=%0b, actual status=%0d value=%0d last=%0b"},
                                 $time, want.status, want.out_value, want.last_of_run,
                                 rsp.status, rsp.out_value, rsp.last_of_run);
                        fail_count++;
                    end
                end
            end
            pending <= expected_rsp_q.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: stimulus, result back-pressure and the verdict.
module testbench;
    import dq_pkg::*;

    // Request codes above the list code are not defined and must be ignored by the block.
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MID   = 3'd6;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_ZERO = 32'sh0000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_ONES = 32'shffff_ffff;
    localparam logic signed [VALUE_W-1:0] WORD_ODD  = 32'sh5555_5555;
    localparam logic signed [VALUE_W-1:0] WORD_EVEN = 32'shaaaa_aaaa;

    localparam int RANDOM_ITEMS = 250;
    // A full listing is the longest job of the block, so the final drain is sized from the queue depth.
    localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 8;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef enum {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    dq_req_t req       = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    dq_rsp_t rsp;

    // When set, both sides run back to back with no idle cycles.
    logic    quiet     = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int empty_reports;
    int longest_list;

    int req_count     = 0;
    int ignored_count = 0;
    int rsp_hold      = 0;
    int rsp_draw;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    double_ended_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    dq_checker #(.DEPTH(DEPTH_DEF)) CHECK (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .full_refusals (full_refusals),
        .empty_reports (empty_reports),
        .longest_list  (longest_list)
    );

    // Result side back-pressure. After each accepted result transaction the receiver draws
    // how many cycles it holds stall high before it takes the next one. The hold runs
    // whether or not a result is waiting, so stalls land on every phase of a listing.
    always @(posedge clk)
    begin
        if (rsp_stall)
        begin
            if (rsp_hold <= 1)
            begin
                rsp_stall <= 1'b0;
            end
            rsp_hold <= rsp_hold - 1;
        end
        else if (rst_n && rsp_valid)
        begin
            rsp_draw = quiet ? 0 : $urandom_range(0, 8);
            if (rsp_draw > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold  <= rsp_draw;
            end
        end
    end

    // Random word, with the extremes of the signed range, zero and all ones turning up often.
    function automatic logic signed [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_ZERO;
            3:       return WORD_ONES;
            default: return $urandom();
        endcase
    endfunction

    // Sends one request transaction. It is entered and left just after a rising edge; with no
    // gap drawn, valid simply stays high and the new payload replaces the accepted one.
    task automatic send_req(input logic [2:0] code, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req.req_type   <= code;
        req.push_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!(req_valid && !req_stall));
        req_count++;
    endtask

    initial
    begin
        traffic_mode_t mode;
        logic [2:0]    code;
        int            sent;
        int            len;
        int            r;
        int            push_lim;
        int            pop_lim;
        int            list_lim;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every request on an empty queue, the word extremes at both ends,
        // unused codes, and emptying the queue by removing its only entry from either end.
        send_req(REQ_LIST_ALL, WORD_ZERO);
        send_req(REQ_POP_FRONT, WORD_MAX);
        send_req(REQ_POP_BACK, WORD_MIN);
        send_req(REQ_PUSH_FRONT, WORD_MAX);
        send_req(REQ_PUSH_BACK, WORD_MIN);
        send_req(REQ_PUSH_FRONT, WORD_ZERO);
        send_req(REQ_PUSH_BACK, WORD_ONES);
        send_req(REQ_LIST_ALL, WORD_ONES);
        send_req(REQ_UNUSED_FIRST, pick_word());
        send_req(REQ_UNUSED_MID, pick_word());
        send_req(REQ_UNUSED_LAST, pick_word());
        send_req(REQ_POP_BACK, WORD_ZERO);
        send_req(REQ_POP_FRONT, WORD_ZERO);
        send_req(REQ_LIST_ALL, WORD_ZERO);
        send_req(REQ_POP_FRONT, WORD_ZERO);
        send_req(REQ_POP_BACK, WORD_ZERO);
        send_req(REQ_LIST_ALL, WORD_ZERO);
        send_req(REQ_PUSH_BACK, WORD_ODD);
        send_req(REQ_PUSH_FRONT, WORD_EVEN);
        send_req(REQ_POP_FRONT, WORD_ZERO);
        send_req(REQ_POP_FRONT, WORD_ZERO);
        send_req(REQ_POP_BACK, WORD_ZERO);
        ignored_count = 3;

        // Random part in rounds. Fill rounds drive the queue up to full and into refused
        // pushes, drain rounds take it back to empty, and mixed rounds keep the front slot
        // wandering around the ring. The first round always fills.
        sent = 0;
        mode = MODE_FILL;
        while (sent < RANDOM_ITEMS)
        begin
            len = $urandom_range(20, 50);
            quiet <= ($urandom_range(0, 4) == 0);
            case (mode)
                MODE_FILL:
                begin
                    push_lim = 85;
                    pop_lim  = 93;
                    list_lim = 98;
                end
                MODE_DRAIN:
                begin
                    push_lim = 12;
                    pop_lim  = 85;
                    list_lim = 96;
                end
                default:
                begin
                    push_lim = 40;
                    pop_lim  = 80;
                    list_lim = 95;
                end
            endcase
            for (int k = 0; k < len && sent < RANDOM_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < push_lim)
                begin
                    code = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                end
                else if (r < pop_lim)
                begin
                    code = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
                end
                else if (r < list_lim)
                begin
                    code = REQ_LIST_ALL;
                end
                else
                begin
                    code = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
                end
                if (code >= REQ_UNUSED_FIRST)
                begin
                    ignored_count++;
                end
                else
                begin
                    sent++;
                end
                send_req(code, pick_word());
            end
            mode = traffic_mode_t'($urandom_range(0, 2));
        end
        req_valid <= 1'b0;

        // The checker updates its count of expected results as a register.
        // Wait for every predicted result, then give a stray late result time to show up.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d request transactions (%0d with unused codes), %0d results.",
                 req_count, ignored_count, checked);
        $display("Refused pushes on a full queue: %0d, empty reports: %0d, longest list: %0d.",
                 full_refusals, empty_reports, longest_list);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected.", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
verif/dq_checker.sv
verif/testbench.sv
